/* rtl/uid_rl_pkg.sv */
// Package for the UID range-list membership core.
// Holds value widths, character codes, verdict codes and the result layout.
// No dependencies.
package uid_rl_pkg;

  // Width of the decimal bounds; values wrap modulo 2^UidBits (8 to 64)
  localparam int unsigned UidBits  = 32;
  localparam int unsigned UidW     = 32;
  localparam int unsigned ChW      = 8;
  localparam int unsigned CmpW     = (UidBits > UidW) ? UidBits : UidW;
  localparam int unsigned InDataW  = ((ChW + UidW + 7) / 8) * 8;
  localparam int unsigned ResW     = 3;
  localparam int unsigned OutDataW = ((ResW + 7) / 8) * 8;

  localparam logic [ChW-1:0] ChNul   = 8'h00;
  localparam logic [ChW-1:0] ChComma = 8'h2C;
  localparam logic [ChW-1:0] ChDash  = 8'h2D;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;

  localparam logic [1:0] VerdPending = 2'd0;
  localparam logic [1:0] VerdCovered = 2'd1;
  localparam logic [1:0] VerdGap     = 2'd2;
  localparam logic [1:0] VerdBad     = 2'd3;

  // Result bits from the highest down
  typedef struct packed {
    logic malformed;
    logic is_recent;
    logic is_unseen;
  } result_t;

endpackage

/* rtl/uid_range_list_membership_core.sv */
// Top level of the UID range-list membership core.
// Uses uid_rl_pkg for widths, character codes and verdict codes.
//
// Usage: feed one character of a seen-range list such as "1-5,9,12-20" per
// item on the s_axis channel, together with the UID under test. The block
// builds the decimal bounds of each entry and settles on the first entry
// whose upper bound reaches the UID. A zero character ends the string and
// produces one result item on m_axis; every other character produces none.
// Throughput: one character per cycle unless a held terminator stalls the input. An item
// passes an input register and the parse logic; a terminator's result is loaded
// into the result register, which drives m_axis_tvalid. The parse state is
// updated from the input register stage, so consecutive characters wait on one
// another only when a terminator is held there.
// Reset clears the parse state to an empty entry with no verdict and empties
// both the input register and the result register.
// When the receiver stalls, the result stays in its register; characters
// keep flowing in until a second terminator reaches the input register,
// which then holds and deasserts s_axis_tready until the result is taken.
module uid_range_list_membership_core
  import uid_rl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] ch, [39:8] uid
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [0] is_unseen, [1] is_recent, [2] malformed
);

  logic               s1_valid_q;
  logic [ChW-1:0]     s1_ch_q;
  logic [UidW-1:0]    s1_uid_q;
  logic               s1_advance;
  logic               s1_is_term;

  logic [UidBits-1:0] low_q, low_d;
  logic [UidBits-1:0] high_q, high_d;
  logic               upper_q, upper_d;
  logic               open_q, open_d;
  logic [1:0]         verd_q, verd_d;

  logic               res_valid_q;
  result_t            res_q, res_d;
  logic               res_load;

  logic [UidBits-1:0] bound_hi;
  logic [CmpW-1:0]    uid_ext, hi_ext, lo_ext;
  logic               reach_hi, below_lo;
  logic [3:0]         digit;
  logic [UidBits-1:0] acc_src, acc_next;
  logic [1:0]         close_verd;
  logic [1:0]         term_verd;

  assign s1_is_term    = (s1_ch_q == ChNul);
  assign s1_advance    = !s1_is_term || !res_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_ch_q  <= s_axis_tdata[ChW-1:0];
      s1_uid_q <= s_axis_tdata[ChW+UidW-1:ChW];
    end
  end

  // Entry close compare
  assign bound_hi = upper_q ? high_q : low_q;
  assign uid_ext  = CmpW'(s1_uid_q);
  assign hi_ext   = CmpW'(bound_hi);
  assign lo_ext   = CmpW'(low_q);
  assign reach_hi = (uid_ext <= hi_ext);
  assign below_lo = (uid_ext < lo_ext);
  assign close_verd = below_lo ? VerdGap : VerdCovered;

  // Decimal accumulate: x*10 + d as two shifted adds
  assign digit    = 4'(s1_ch_q - ChZero);
  assign acc_src  = upper_q ? high_q : low_q;
  assign acc_next = {acc_src[UidBits-4:0], 3'b000} + {acc_src[UidBits-2:0], 1'b0}
                    + UidBits'(digit);

  assign term_verd = (verd_q == VerdPending && open_q && reach_hi) ? close_verd : verd_q;

  always_comb begin
    low_d    = low_q;
    high_d   = high_q;
    upper_d  = upper_q;
    open_d   = open_q;
    verd_d   = verd_q;
    res_load = 1'b0;
    res_d.is_unseen = (term_verd == VerdPending) || (term_verd == VerdGap);
    res_d.is_recent = (term_verd == VerdPending);
    res_d.malformed = (term_verd == VerdBad);

    if (s1_valid_q && s1_advance) begin
      if (s1_is_term) begin
        res_load = 1'b1;
        low_d    = '0;
        high_d   = '0;
        upper_d  = 1'b0;
        open_d   = 1'b0;
        verd_d   = VerdPending;
      end else if (verd_q == VerdPending) begin
        if (s1_ch_q inside {[ChZero:ChNine]}) begin
          if (upper_q) begin
            high_d = acc_next;
          end else begin
            low_d = acc_next;
          end
          open_d = 1'b1;
        end else if (s1_ch_q == ChDash && !upper_q) begin
          upper_d = 1'b1;
          high_d  = '0;
          open_d  = 1'b1;
        end else if (s1_ch_q == ChComma) begin
          if (reach_hi) begin
            verd_d = close_verd;
          end else begin
            // entry below the UID: drop it and move on
            low_d   = '0;
            high_d  = '0;
            upper_d = 1'b0;
            open_d  = 1'b0;
          end
        end else begin
          verd_d = VerdBad;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= '0;
      high_q  <= '0;
      upper_q <= 1'b0;
      open_q  <= 1'b0;
      verd_q  <= VerdPending;
    end else begin
      low_q   <= low_d;
      high_q  <= high_d;
      upper_q <= upper_d;
      open_q  <= open_d;
      verd_q  <= verd_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = OutDataW'(res_q);

endmodule

/* rtl/uid_rl_checker.sv */
// Port-level checker for the UID range-list membership core.
// Uses uid_rl_pkg; bound to uid_range_list_membership_core below.
module uid_rl_checker
  import uid_rl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // A malformed list carries no counts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[2] && (m_axis_tdata[0] || m_axis_tdata[1])))
    else $error("malformed result with counts set");

  // Recent implies unseen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("recent without unseen");

  // A result needs a terminator accepted on the input before it appears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready
                                   && s_axis_tdata[ChW-1:0] == ChNul, 2))
    else $error("result without terminator");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind uid_range_list_membership_core uid_rl_checker u_uid_rl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/uid_range_list_membership_core_test.sv */
// Self-checking testbench for uid_range_list_membership_core.
// Streams range lists one character per item, predicts each verdict in step with
// the block and checks every result item; needs rtl/uid_rl_pkg.sv and the core.
`timescale 1ns / 100ps

module uid_range_list_membership_core_test;
  import uid_rl_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned ReportCap     = 60;
  localparam int unsigned HoldCycles    = 300;

  typedef logic [UidBits-1:0] bound_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [7:0] ch, [39:8] uid
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [0] is_unseen, [1] is_recent, [2] malformed

  uid_range_list_membership_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Parser state as the block should hold it
  bound_t     bound_lo;
  bound_t     bound_hi;
  bit         saw_dash;
  bit         entry_busy;
  logic [1:0] verdict;

  result_t     pending_verdicts[$];
  int unsigned err_cnt;
  int unsigned items_sent;
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          rx_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic void clear_entry();
    bound_lo   = '0;
    bound_hi   = '0;
    saw_dash   = 1'b0;
    entry_busy = 1'b0;
  endfunction

  function automatic void settle_entry(input logic [UidW-1:0] uid);
    bound_t top;
    top = saw_dash ? bound_hi : bound_lo;
    if (CmpW'(uid) <= CmpW'(top)) begin
      verdict = (CmpW'(uid) < CmpW'(bound_lo)) ? VerdGap : VerdCovered;
    end else begin
      clear_entry();
    end
  endfunction

  // Advance the parser by one accepted character; queue a verdict on the terminator
  function automatic void parse_char(input logic [ChW-1:0] ch, input logic [UidW-1:0] uid);
    result_t res;
    if (ch == ChNul) begin
      if (verdict == VerdPending && entry_busy) begin
        settle_entry(uid);
      end
      res.is_unseen = (verdict == VerdPending) || (verdict == VerdGap);
      res.is_recent = (verdict == VerdPending);
      res.malformed = (verdict == VerdBad);
      pending_verdicts.push_back(res);
      clear_entry();
      verdict = VerdPending;
    end else if (verdict == VerdPending) begin
      if (ch >= ChZero && ch <= ChNine) begin
        if (saw_dash) begin
          bound_hi = bound_hi * bound_t'(10) + bound_t'(ch - ChZero);
        end else begin
          bound_lo = bound_lo * bound_t'(10) + bound_t'(ch - ChZero);
        end
        entry_busy = 1'b1;
      end else if (ch == ChDash && !saw_dash) begin
        saw_dash   = 1'b1;
        bound_hi   = '0;
        entry_busy = 1'b1;
      end else if (ch == ChComma) begin
        settle_entry(uid);
      end else begin
        verdict = VerdBad;
      end
    end
  endfunction

  // Offer one item, wait for the handshake, then maybe idle for a while
  task automatic send_char(input logic [ChW-1:0] ch, input logic [UidW-1:0] uid);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {uid, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    parse_char(ch, uid);
    items_sent++;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_list(input string s, input logic [UidW-1:0] uid, input bit jitter_uid);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], (jitter_uid && $urandom_range(0, 3) == 0) ? UidW'($urandom) : uid);
    end
    send_char(ChNul, uid);
  endtask

  // Stop offering and hold until every verdict has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Ascending ranges with random content; the UID is picked near a bound half of the time
  function automatic string random_list(output logic [UidW-1:0] uid);
    string           s;
    longint unsigned cur;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned marks[$];
    int unsigned     n;
    bit              wide;
    s    = "";
    wide = ($urandom_range(0, 5) == 0);
    cur  = wide ? longint'($urandom) : longint'($urandom_range(0, 40));
    n    = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      lo = cur;
      hi = lo + (wide ? $urandom_range(0, 100000) : $urandom_range(0, 8));
      if (i != 0) s = {s, ","};
      if (hi == lo && $urandom_range(0, 1) == 0) begin
        s = {s, $sformatf("%0d", lo)};
      end else begin
        s = {s, $sformatf("%0d-%0d", lo, hi)};
      end
      marks.push_back(lo);
      marks.push_back(hi);
      cur = hi + 1 + (wide ? $urandom_range(0, 1000000) : $urandom_range(0, 6));
    end
    case ($urandom_range(0, 7))
      0: uid = $urandom;
      1: uid = '0;
      2: uid = '1;
      3: uid = UidW'(cur);
      default: uid = UidW'(marks[$urandom_range(0, marks.size() - 1)] +
                           $urandom_range(0, 2) - 1);
    endcase
    return s;
  endfunction

  task automatic test_directed();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_list("", '1, 1'b0);            // nothing seen: unseen and recent
    send_list("1-5", 32'd3, 1'b0);      // inside a range
    send_list("9,12", 32'd10, 1'b0);    // gap before a bare number at the terminator
    send_list("2-", 32'd0, 1'b0);       // dash with no upper digits
    send_list(",x", 32'd0, 1'b0);       // empty entry matches zero, rest ignored
    send_list("1--", 32'd1, 1'b0);      // second dash in one entry
    send_list("a", 32'd0, 1'b0);        // bogus character
    wait_drained();
  endtask

  task automatic test_random_lists();
    int unsigned     goal;
    int unsigned     p;
    string           s;
    logic [UidW-1:0] uid;
    goal = items_sent + 450;
    while (items_sent < goal) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      s = random_list(uid);
      // break some lists: stray byte, double dash, empty entries, trailing separator
      if ($urandom_range(0, 5) == 0) begin
        p = $urandom_range(0, s.len() - 1);
        case ($urandom_range(0, 3))
          0: s.putc(p, 8'($urandom_range(1, 255)));
          1: s = {s, "--"};
          2: s = {s.substr(0, p), ",,", s.substr(p + 1, s.len() - 1)};
          default: s = {s, ($urandom_range(0, 1) != 0) ? "," : "-"};
        endcase
      end
      send_list(s, uid, $urandom_range(0, 19) == 0);
    end
    wait_drained();
  endtask

  task automatic test_stalled_receiver();
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b1;
    rx_hold_req = 1'b1;
    repeat (20) begin
      send_list(($urandom_range(0, 1) != 0) ? "7" : "", $urandom_range(0, 9), 1'b0);
    end
    wait_drained();
  endtask

  task automatic test_streaming_no_idle();
    int unsigned     goal;
    string           s;
    logic [UidW-1:0] uid;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    goal = items_sent + 250;
    while (items_sent < goal) begin
      s = random_list(uid);
      send_list(s, uid, 1'b0);
    end
    wait_drained();
  endtask

  task automatic test_noise();
    int unsigned     goal;
    int unsigned     len;
    string           parse_set;
    logic [UidW-1:0] uid;
    parse_set  = "0123456789,-";
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    goal = items_sent + 180;
    while (items_sent < goal) begin
      len = $urandom_range(1, 6);
      uid = $urandom;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 1) != 0) begin
          send_char(parse_set[$urandom_range(0, parse_set.len() - 1)], uid);
        end else begin
          send_char(ChW'($urandom_range(1, 255)), uid);
        end
      end
      send_char(ChNul, uid);
    end
    wait_drained();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    err_cnt     = 0;
    items_sent  = 0;
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_req = 1'b0;
    clear_entry();
    verdict = VerdPending;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_lists();
    test_stalled_receiver();
    test_streaming_no_idle();
    test_noise();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left  = 0;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic report_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      if (err_cnt < ReportCap) begin
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
      end
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[ResW-1:0]);
      if (pending_verdicts.size() == 0) begin
        if (err_cnt < ReportCap) begin
          $display("%0t: unexpected result, expected none, actual %03b", $time, got);
        end
        err_cnt++;
      end else begin
        want = pending_verdicts.pop_front();
        report_field("is_unseen", want.is_unseen, got.is_unseen);
        report_field("is_recent", want.is_recent, got.is_recent);
        report_field("malformed", want.malformed, got.malformed);
      end
    end
  end

  // End the run if neither side moves an item for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= WatchdogLimit) begin
          $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                   $time, quiet, pending_verdicts.size());
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

endmodule
